// File: hw/rtl/rau_pkg.sv
package rau_pkg;

  localparam int WORD_BITS = 32;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic               is_equal;
    logic               invalid;
  } out_item_t;

  // Request and response between the sequencer and the divider.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

// File: hw/rtl/rau_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rau_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic                busy_r, busy_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  word_t               q_r, q_nxt;
  word_t               rem_r, rem_nxt;
  word_t               dvs_r, dvs_nxt;
  logic                done_r, done_nxt;
  logic [WORD_BITS:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[WORD_BITS-1]} - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(WORD_BITS);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[WORD_BITS]) begin
        rem_nxt = trial[WORD_BITS-1:0];
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_BITS-2:0], q_r[WORD_BITS-1]};
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |=> busy_r || done_r) else $error("divider dropped work");

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// Sequencing: equal-denominator add/subtract and invalid inputs go from ST_DISP straight
//   to ST_OUT; multiply, divide and compare pass through ST_MUL1 first. Add/subtract with
//   unequal denominators run the gcd loop and three quotients on one 32-step divider,
//   then scale the operands in ST_SCL.
// Throughput: one transaction at a time; in_stall is high while busy or holding a result.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no output.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_item_t out_data
);
  import rau_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DISP = 9'b000000010,
    ST_MUL1 = 9'b000000100,
    ST_GCD  = 9'b000001000,
    ST_LCM  = 9'b000010000,
    ST_FA   = 9'b000100000,
    ST_FB   = 9'b001000000,
    ST_SCL  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t    state_r, state_nxt;
  logic [2:0] mode_r;
  word_t     an_r, ad_r, bn_r, bd_r;
  // gcd operands, then lcm and scale factors
  word_t     gx_r, gx_nxt, gy_r, gy_nxt;
  word_t     lcm_r, lcm_nxt, fa_r, fa_nxt;
  logic      neg_r, neg_nxt;
  logic      wait_r, wait_nxt;
  // shared multiplier with registered product
  word_t     mul_a, mul_b, prod_r;
  word_t     p0_r, p0_nxt;
  out_item_t res_r, res_nxt;
  logic      ovalid_r, ovalid_nxt;
  div_req_t  dreq;
  div_rsp_t  drsp;
  word_t     qsigned;

  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic word_t mag(word_t x);
    return x[WORD_BITS-1] ? word_t'(-x) : x;
  endfunction

  assign in_stall  = (state_r != ST_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = res_r;
  assign qsigned   = neg_r ? word_t'(-drsp.quot) : drsp.quot;

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      ST_DISP: begin
        case (mode_r)
          MODE_MUL: begin mul_a = an_r; mul_b = bn_r; end
          MODE_DIV, MODE_CMP: begin mul_a = an_r; mul_b = bd_r; end
          default: begin mul_a = ad_r; mul_b = bd_r; end
        endcase
      end
      ST_MUL1: begin
        case (mode_r)
          MODE_MUL: begin mul_a = ad_r; mul_b = bd_r; end
          default: begin mul_a = bn_r; mul_b = ad_r; end
        endcase
      end
      // hold ad*bd in prod_r for the whole gcd loop
      ST_GCD: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      ST_SCL: begin
        case (gx_r[1:0])
          2'd0: begin mul_a = an_r; mul_b = fa_r; end
          2'd1: begin mul_a = ad_r; mul_b = fa_r; end
          2'd2: begin mul_a = bn_r; mul_b = lcm_r; end
          default: begin mul_a = bd_r; mul_b = lcm_r; end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    gx_nxt     = gx_r;
    gy_nxt     = gy_r;
    lcm_nxt    = lcm_r;
    fa_nxt     = fa_r;
    neg_nxt    = neg_r;
    wait_nxt   = wait_r;
    p0_nxt     = p0_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && out_stall;
    dreq       = '{start: 1'b0, dividend: gx_r, divisor: gy_r};
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        res_nxt = '0;
        if (ad_r == '0 || bd_r == '0 || mode_r > MODE_CMP) begin
          res_nxt.invalid = 1'b1;
          state_nxt = ST_OUT;
        end else if ((mode_r == MODE_ADD || mode_r == MODE_SUB) && ad_r == bd_r) begin
          res_nxt.result_num = (mode_r == MODE_ADD) ? an_r + bn_r : an_r - bn_r;
          res_nxt.result_den = ad_r;
          state_nxt = ST_OUT;
        end else if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
          gx_nxt = mag(ad_r);
          gy_nxt = mag(bd_r);
          wait_nxt = 1'b0;
          state_nxt = ST_GCD;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        // prod_r holds the first product, the multiplier now forms the second
        p0_nxt = prod_r;
        state_nxt = ST_OUT;
        wait_nxt = 1'b1;
      end
      ST_GCD: begin
        // prod_r keeps ad*bd while the loop runs
        if (!wait_r) begin
          if (gy_r == '0) begin
            dreq = '{start: 1'b1, dividend: mag(prod_r), divisor: gx_r};
            neg_nxt = prod_r[WORD_BITS-1];
            wait_nxt = 1'b1;
            state_nxt = ST_LCM;
          end else begin
            dreq.start = 1'b1;
            wait_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          gx_nxt = gy_r;
          gy_nxt = drsp.rem;
          wait_nxt = 1'b0;
        end
      end
      ST_LCM: begin
        if (drsp.done) begin
          lcm_nxt = qsigned;
          dreq = '{start: 1'b1, dividend: mag(qsigned), divisor: mag(ad_r)};
          neg_nxt = qsigned[WORD_BITS-1] ^ ad_r[WORD_BITS-1];
          state_nxt = ST_FA;
        end
      end
      ST_FA: begin
        if (drsp.done) begin
          fa_nxt = qsigned;
          dreq = '{start: 1'b1, dividend: mag(lcm_r), divisor: mag(bd_r)};
          neg_nxt = lcm_r[WORD_BITS-1] ^ bd_r[WORD_BITS-1];
          state_nxt = ST_FB;
        end
      end
      ST_FB: begin
        if (drsp.done) begin
          lcm_nxt = qsigned;   // reuse: now holds fb
          gx_nxt = '0;         // reuse as scale step count
          state_nxt = ST_SCL;
        end
      end
      ST_SCL: begin
        // prod_r holds the product selected in the previous scale step
        gx_nxt = gx_r + 1'b1;
        case (gx_r[2:0])
          3'd1: res_nxt.result_num = prod_r;
          3'd2: res_nxt.result_den = prod_r;
          3'd3: p0_nxt = prod_r;
          3'd4: begin
            if (res_r.result_den == '0 || prod_r == '0) begin
              res_nxt = '0;
              res_nxt.invalid = 1'b1;
            end else begin
              res_nxt.result_num = (mode_r == MODE_ADD) ? res_r.result_num + p0_r
                                                        : res_r.result_num - p0_r;
            end
            wait_nxt = 1'b0;
            state_nxt = ST_OUT;
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        if (wait_r) begin
          // finish multiply, divide or compare with prod_r = second product
          res_nxt = '0;
          if (mode_r == MODE_CMP) begin
            res_nxt.is_equal = (p0_r == prod_r);
          end else if (prod_r == '0) begin
            res_nxt.invalid = 1'b1;
          end else begin
            res_nxt.result_num = p0_r;
            res_nxt.result_den = prod_r;
          end
        end
        ovalid_nxt = 1'b1;
        wait_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      wait_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wait_r   <= wait_nxt;
    end
    if (in_valid && !in_stall) begin
      mode_r <= in_data.mode;
      an_r   <= in_data.a_num;
      ad_r   <= in_data.a_den;
      bn_r   <= in_data.b_num;
      bd_r   <= in_data.b_den;
    end
    prod_r <= word_t'(mul_a * mul_b);
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    lcm_r  <= lcm_nxt;
    fa_r   <= fa_nxt;
    neg_r  <= neg_nxt;
    p0_r   <= p0_nxt;
    res_r  <= res_nxt;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("accepting while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT) else $error("stray result");
  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.result_den == '0 && !out_data.is_equal)
    else $error("invalid result carries data");

endmodule
